// ===== hdl/mra_pkg.sv =====
// Shared types and constants of the maximal-rectangles atlas allocator.
`default_nettype none
package mra_pkg;
    localparam int MAX_FREE    = 64;
    localparam int COORD_BITS  = 13;
    localparam int IDX_W       = $clog2(MAX_FREE);
    localparam int CNT_W       = $clog2(MAX_FREE + 1);
    localparam int LIM_I       = ((1 << COORD_BITS) - 1 > 4096) ? 4096 : (1 << COORD_BITS) - 1;
    localparam logic [COORD_BITS-1:0] SHEET_LIM   = COORD_BITS'(LIM_I);
    localparam logic [COORD_BITS-1:0] SHEET_RESET = COORD_BITS'(1024);
    localparam logic [CNT_W-1:0]      FREE_MAX    = CNT_W'(MAX_FREE);

    typedef enum logic [0:0] {
        REG_SHEET_WIDTH  = 1'b0,
        REG_SHEET_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] x0;
    } rect_t;

    localparam int RECT_W = $bits(rect_t);

    // Result of the shared geometry unit.
    typedef struct packed {
        logic                  fits;
        logic                  overlap;
        logic                  contained;
        logic                  keep;
        rect_t                 rem;
        logic [COORD_BITS-1:0] a_w;
        logic [COORD_BITS-1:0] a_h;
    } geo_t;
endpackage
`default_nettype wire

// ===== hdl/maxrects_atlas_allocator.sv =====
// Top level of the maximal-rectangles atlas allocator with its sequencer.
//
// The block packs rectangles onto a sheet. Each input transfer carries an
// action flag in s_tuser and a requested width and height in s_tdata. An
// allocate request returns one result transfer with a granted flag, the
// top-left corner of the placed rectangle, and a sticky list overflow flag.
// A clear action resets the free list to the whole sheet and returns one
// result transfer with granted low.
// The free list lives in a 64-entry RAM with one read and one write port;
// a second RAM holds the rectangles cut by the placement. One geometry unit
// does every test under a small sequencer, and each RAM read is registered.
// An allocation searches the list, then compacts it, cuts each overlapped
// rectangle into up to four remainders, and prunes entries held inside others.
// s_tready is high only while the sequencer is idle. A finished result sits
// in the output register; the next request is accepted while it waits, and
// its own result waits for the receiver to take the previous one.
// After reset the init state loads a 1024 by 1024 sheet into entry 0 before the
// first request is accepted. Sheet size writes take effect at the next clear.
`default_nettype none
module maxrects_atlas_allocator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration write port.
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_index,
    input  wire logic [mra_pkg::COORD_BITS-1:0] cfg_data,
    // Request channel.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,  // req_width, req_height
    input  wire logic [0:0]                    s_tuser,  // action
    // Result channel.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [31:0]                   m_tdata,  // pos_x, pos_y
    output logic      [1:0]                    m_tuser   // granted, list_overflow
);
    import mra_pkg::*;

    typedef enum logic [15:0] {
        ST_INIT      = 16'h0001,
        ST_IDLE      = 16'h0002,
        ST_FIND_RD   = 16'h0004,
        ST_FIND_CHK  = 16'h0008,
        ST_CARVE_RD  = 16'h0010,
        ST_CARVE_CHK = 16'h0020,
        ST_CUT_RD    = 16'h0040,
        ST_CUT_LD    = 16'h0080,
        ST_CUT_GEN   = 16'h0100,
        ST_PR_ARD    = 16'h0200,
        ST_PR_ALD    = 16'h0400,
        ST_PR_BRD    = 16'h0800,
        ST_PR_BCHK   = 16'h1000,
        ST_SH_RD     = 16'h2000,
        ST_SH_WR     = 16'h4000,
        ST_DONE      = 16'h8000
    } state_t;

    state_t                state_reg, state_next;
    logic [COORD_BITS-1:0] sheet_w_reg, sheet_w_next, sheet_h_reg, sheet_h_next;
    logic [COORD_BITS-1:0] lw_reg, lw_next, lh_reg, lh_next;
    logic [COORD_BITS-1:0] req_w_reg, req_w_next, req_h_reg, req_h_next;
    logic [CNT_W-1:0]      count_reg, count_next, i_reg, i_next, j_reg, j_next;
    logic [CNT_W-1:0]      kept_reg, kept_next, n_reg, n_next;
    logic [1:0]            k_reg, k_next;
    rect_t                 p_reg, p_next, a_reg, a_next;
    logic                  found_reg, found_next, ovf_reg, ovf_next;
    logic                  res_g_reg, res_g_next;
    logic [COORD_BITS-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic                  mv_reg, mv_next, mg_reg, mg_next, mo_reg, mo_next;
    logic [COORD_BITS-1:0] mx_reg, mx_next, my_reg, my_next;

    // RAM ports.
    logic                  fw_en, tw_en;
    logic [IDX_W-1:0]      fw_addr, fr_addr, tw_addr, tr_addr;
    rect_t                 fw_data, frd, trd;
    logic [CNT_W-1:0]      sh_src;

    // Geometry unit.
    rect_t                 ga, gb;
    geo_t                  geo;
    logic [COORD_BITS-1:0] cfg_sat;
    logic                  s_fire;

    mra_ram #(.WIDTH(RECT_W), .DEPTH(MAX_FREE)) u_free_ram (
        .aclk (aclk), .we (fw_en), .waddr (fw_addr), .wdata (fw_data),
        .raddr (fr_addr), .rdata (frd)
    );

    mra_ram #(.WIDTH(RECT_W), .DEPTH(MAX_FREE)) u_taken_ram (
        .aclk (aclk), .we (tw_en), .waddr (tw_addr), .wdata (frd),
        .raddr (tr_addr), .rdata (trd)
    );

    mra_geom u_geom (
        .a_rect (ga), .b_rect (gb), .req_w (req_w_reg), .req_h (req_h_reg),
        .part (k_reg), .geo (geo)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {6'd0, my_reg, mx_reg};
    assign m_tuser  = {mo_reg, mg_reg};
    assign sh_src   = j_reg + CNT_W'(1);

    // The probed rectangle is the latched one while cutting or while it is
    // tested for containment against the rest of the list.
    assign ga = (state_reg == ST_CUT_GEN || state_reg == ST_PR_BCHK) ? a_reg : frd;
    assign gb = (state_reg == ST_PR_BCHK) ? frd : p_reg;

    always_comb begin
        cfg_sat = cfg_data;
        if (cfg_data == '0) begin
            cfg_sat = COORD_BITS'(1);
        end else if (cfg_data > SHEET_LIM) begin
            cfg_sat = SHEET_LIM;
        end
    end

    // Read addresses follow the state; the registered data is used in the next cycle.
    always_comb begin
        fr_addr = i_reg[IDX_W-1:0];
        if (state_reg == ST_PR_BRD) begin
            fr_addr = j_reg[IDX_W-1:0];
        end else if (state_reg == ST_SH_RD) begin
            fr_addr = sh_src[IDX_W-1:0];
        end
        tr_addr = i_reg[IDX_W-1:0];
    end

    always_comb begin
        state_next   = state_reg;
        sheet_w_next = sheet_w_reg;
        sheet_h_next = sheet_h_reg;
        lw_next      = lw_reg;
        lh_next      = lh_reg;
        req_w_next   = req_w_reg;
        req_h_next   = req_h_reg;
        count_next   = count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        kept_next    = kept_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        p_next       = p_reg;
        a_next       = a_reg;
        found_next   = found_reg;
        ovf_next     = ovf_reg;
        res_g_next   = res_g_reg;
        res_x_next   = res_x_reg;
        res_y_next   = res_y_reg;
        mv_next      = mv_reg;
        mg_next      = mg_reg;
        mo_next      = mo_reg;
        mx_next      = mx_reg;
        my_next      = my_reg;
        fw_en        = 1'b0;
        fw_addr      = kept_reg[IDX_W-1:0];
        fw_data      = frd;
        tw_en        = 1'b0;
        tw_addr      = n_reg[IDX_W-1:0];

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SHEET_WIDTH:  sheet_w_next = cfg_sat;
                REG_SHEET_HEIGHT: sheet_h_next = cfg_sat;
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_INIT: begin
                fw_en      = 1'b1;
                fw_addr    = '0;
                fw_data    = '{y1: SHEET_RESET, x1: SHEET_RESET, y0: '0, x0: '0};
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    req_w_next = s_tdata[COORD_BITS-1:0];
                    req_h_next = s_tdata[2*COORD_BITS-1:COORD_BITS];
                    res_g_next = 1'b0;
                    res_x_next = '0;
                    res_y_next = '0;
                    if (s_tuser[0]) begin
                        fw_en      = 1'b1;
                        fw_addr    = '0;
                        fw_data    = '{y1: sheet_h_reg, x1: sheet_w_reg, y0: '0, x0: '0};
                        count_next = CNT_W'(1);
                        lw_next    = sheet_w_reg;
                        lh_next    = sheet_h_reg;
                        state_next = ST_DONE;
                    end else if (s_tdata[COORD_BITS-1:0] > lw_reg ||
                                 s_tdata[2*COORD_BITS-1:COORD_BITS] > lh_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        i_next     = '0;
                        found_next = 1'b0;
                        state_next = ST_FIND_RD;
                    end
                end
            end
            ST_FIND_RD: begin
                if (i_reg == count_reg) begin
                    i_next     = '0;
                    kept_next  = '0;
                    n_next     = '0;
                    state_next = found_reg ? ST_CARVE_RD : ST_DONE;
                end else begin
                    state_next = ST_FIND_CHK;
                end
            end
            ST_FIND_CHK: begin
                // The last holder in list order wins.
                if (geo.fits) begin
                    p_next     = '{y1: frd.y0 + req_h_reg, x1: frd.x0 + req_w_reg,
                                   y0: frd.y0, x0: frd.x0};
                    found_next = 1'b1;
                end
                i_next     = i_reg + CNT_W'(1);
                state_next = ST_FIND_RD;
            end
            ST_CARVE_RD: begin
                if (i_reg == count_reg) begin
                    count_next = kept_reg;
                    i_next     = '0;
                    state_next = ST_CUT_RD;
                end else begin
                    state_next = ST_CARVE_CHK;
                end
            end
            ST_CARVE_CHK: begin
                if (geo.overlap) begin
                    tw_en  = 1'b1;
                    n_next = n_reg + CNT_W'(1);
                end else begin
                    fw_en     = 1'b1;
                    kept_next = kept_reg + CNT_W'(1);
                end
                i_next     = i_reg + CNT_W'(1);
                state_next = ST_CARVE_RD;
            end
            ST_CUT_RD: begin
                if (i_reg == n_reg) begin
                    i_next     = '0;
                    lw_next    = '0;
                    lh_next    = '0;
                    state_next = ST_PR_ARD;
                end else begin
                    state_next = ST_CUT_LD;
                end
            end
            ST_CUT_LD: begin
                a_next     = trd;
                k_next     = 2'd0;
                state_next = ST_CUT_GEN;
            end
            ST_CUT_GEN: begin
                // Left, right, top, bottom remainders, one per cycle.
                if (geo.keep) begin
                    if (count_reg < FREE_MAX) begin
                        fw_en      = 1'b1;
                        fw_addr    = count_reg[IDX_W-1:0];
                        fw_data    = geo.rem;
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_CUT_RD;
                end
            end
            ST_PR_ARD: begin
                if (i_reg == count_reg) begin
                    res_g_next = 1'b1;
                    res_x_next = p_reg.x0;
                    res_y_next = p_reg.y0;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_PR_ALD;
                end
            end
            ST_PR_ALD: begin
                a_next     = frd;
                lw_next    = (geo.a_w > lw_reg) ? geo.a_w : lw_reg;
                lh_next    = (geo.a_h > lh_reg) ? geo.a_h : lh_reg;
                j_next     = '0;
                state_next = ST_PR_BRD;
            end
            ST_PR_BRD: begin
                if (j_reg == count_reg) begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_PR_ARD;
                end else begin
                    state_next = ST_PR_BCHK;
                end
            end
            ST_PR_BCHK: begin
                if (j_reg != i_reg && geo.contained) begin
                    j_next     = i_reg;
                    state_next = ST_SH_RD;
                end else begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = ST_PR_BRD;
                end
            end
            ST_SH_RD: begin
                // Close the gap left by the contained entry, keeping order.
                if (sh_src == count_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_PR_ARD;
                end else begin
                    state_next = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                fw_en      = 1'b1;
                fw_addr    = j_reg[IDX_W-1:0];
                j_next     = sh_src;
                state_next = ST_SH_RD;
            end
            ST_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mg_next    = res_g_reg;
                    mx_next    = res_x_reg;
                    my_next    = res_y_reg;
                    mo_next    = ovf_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            sheet_w_reg <= SHEET_RESET;
            sheet_h_reg <= SHEET_RESET;
            lw_reg      <= SHEET_RESET;
            lh_reg      <= SHEET_RESET;
            count_reg   <= CNT_W'(1);
            ovf_reg     <= 1'b0;
            mv_reg      <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sheet_w_reg <= sheet_w_next;
            sheet_h_reg <= sheet_h_next;
            lw_reg      <= lw_next;
            lh_reg      <= lh_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            mv_reg      <= mv_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_w_reg <= req_w_next;
        req_h_reg <= req_h_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        kept_reg  <= kept_next;
        n_reg     <= n_next;
        k_reg     <= k_next;
        p_reg     <= p_next;
        a_reg     <= a_next;
        res_g_reg <= res_g_next;
        res_x_reg <= res_x_next;
        res_y_reg <= res_y_next;
        mg_reg    <= mg_next;
        mo_reg    <= mo_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
    end

    // The free list never holds more entries than the RAM has.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FREE_MAX)
        else $error("free list count exceeds capacity");

    // Overflow is sticky until reset.
    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared without reset");

    // A result is loaded only from the done state.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mv_reg) |-> $past(state_reg == ST_DONE))
        else $error("result produced outside the done state");
endmodule
`default_nettype wire

// ===== hdl/mra_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module mra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/mra_geom.sv =====
// Shared geometry unit: fit, overlap and containment tests and remainder cutting.
`default_nettype none
module mra_geom (
    input  wire mra_pkg::rect_t                  a_rect,
    input  wire mra_pkg::rect_t                  b_rect,
    input  wire logic [mra_pkg::COORD_BITS-1:0]  req_w,
    input  wire logic [mra_pkg::COORD_BITS-1:0]  req_h,
    input  wire logic [1:0]                      part,
    output mra_pkg::geo_t                        geo
);
    import mra_pkg::*;

    logic [COORD_BITS-1:0] ix0, iy0, ix1, iy1, margin;
    rect_t                 rem;

    always_comb begin
        ix0 = (a_rect.x0 > b_rect.x0) ? a_rect.x0 : b_rect.x0;
        iy0 = (a_rect.y0 > b_rect.y0) ? a_rect.y0 : b_rect.y0;
        ix1 = (a_rect.x1 < b_rect.x1) ? a_rect.x1 : b_rect.x1;
        iy1 = (a_rect.y1 < b_rect.y1) ? a_rect.y1 : b_rect.y1;
        rem = a_rect;
        unique case (part)
            2'd0: begin
                rem.x1 = ix0;
                margin = ix0 - a_rect.x0;
            end
            2'd1: begin
                rem.x0 = ix1;
                margin = a_rect.x1 - ix1;
            end
            2'd2: begin
                rem.y1 = iy0;
                margin = iy0 - a_rect.y0;
            end
            default: begin
                rem.y0 = iy1;
                margin = a_rect.y1 - iy1;
            end
        endcase
        geo.a_w       = a_rect.x1 - a_rect.x0;
        geo.a_h       = a_rect.y1 - a_rect.y0;
        geo.fits      = (req_w <= geo.a_w) && (req_h <= geo.a_h);
        geo.overlap   = (ix1 > ix0) && (iy1 > iy0);
        geo.contained = (a_rect.x0 >= b_rect.x0) && (a_rect.y0 >= b_rect.y0) &&
                        (a_rect.x1 <= b_rect.x1) && (a_rect.y1 <= b_rect.y1);
        geo.keep      = margin > COORD_BITS'(1);
        geo.rem       = rem;
    end
endmodule
`default_nettype wire

// ===== tb/mra_checker.sv =====
// Checker that watches the channels of the atlas allocator and predicts every result.
module mra_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic                           cfg_index,
    input  wire logic [mra_pkg::COORD_BITS-1:0] cfg_data,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [31:0]                    s_tdata,  // req_width, req_height
    input  wire logic [0:0]                     s_tuser,  // action
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [31:0]                    m_tdata,  // pos_x, pos_y
    input  wire logic [1:0]                     m_tuser,  // granted, list_overflow
    output int                                  fails,
    output int                                  placements_left
);
    import mra_pkg::*;

    typedef struct {
        int unsigned x0, y0, x1, y1;
    } box_t;

    typedef struct packed {
        logic                  granted;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic                  overflow;
    } placement_t;

    int unsigned sheet_w, sheet_h, n_free, big_w, big_h;
    bit          ovf;
    box_t        free_list [MAX_FREE];
    box_t        cut_list  [MAX_FREE];
    placement_t  placements [$];

    function automatic int unsigned umax(int unsigned a, int unsigned b);
        return a > b ? a : b;
    endfunction

    function automatic int unsigned umin(int unsigned a, int unsigned b);
        return a < b ? a : b;
    endfunction

    function automatic void load_whole_sheet();
        free_list[0] = '{0, 0, sheet_w, sheet_h};
        n_free = 1;
        big_w  = sheet_w;
        big_h  = sheet_h;
    endfunction

    function automatic void push_free(box_t r);
        if (n_free < MAX_FREE) begin
            free_list[n_free] = r;
            n_free++;
        end else begin
            ovf = 1'b1;
        end
    endfunction

    // Removes every rectangle held inside another one and recomputes the extents.
    function automatic void drop_contained();
        int unsigned i, j, k;
        bit          gone;
        box_t        a, b;
        i = 0;
        big_w = 0;
        big_h = 0;
        while (i < n_free) begin
            a = free_list[i];
            gone = 1'b0;
            big_w = umax(big_w, a.x1 - a.x0);
            big_h = umax(big_h, a.y1 - a.y0);
            for (j = 0; j < n_free; j++) begin
                b = free_list[j];
                if (j != i && a.x0 >= b.x0 && a.y0 >= b.y0 && a.x1 <= b.x1 && a.y1 <= b.y1) begin
                    for (k = i; k + 1 < n_free; k++) free_list[k] = free_list[k+1];
                    n_free--;
                    gone = 1'b1;
                    break;
                end
            end
            if (!gone) i++;
        end
    endfunction

    function automatic void carve_out(box_t p);
        int unsigned i, n, kept, ix0, iy0, ix1, iy1;
        box_t        t, r;
        n = 0;
        kept = 0;
        for (i = 0; i < n_free; i++) begin
            t = free_list[i];
            if (umin(t.x1, p.x1) > umax(t.x0, p.x0) && umin(t.y1, p.y1) > umax(t.y0, p.y0)) begin
                cut_list[n] = t;
                n++;
            end else begin
                free_list[kept] = t;
                kept++;
            end
        end
        n_free = kept;
        for (i = 0; i < n; i++) begin
            t = cut_list[i];
            ix0 = umax(t.x0, p.x0);
            iy0 = umax(t.y0, p.y0);
            ix1 = umin(t.x1, p.x1);
            iy1 = umin(t.y1, p.y1);
            if (ix0 - t.x0 > 1) begin r = t; r.x1 = ix0; push_free(r); end
            if (t.x1 - ix1 > 1) begin r = t; r.x0 = ix1; push_free(r); end
            if (iy0 - t.y0 > 1) begin r = t; r.y1 = iy0; push_free(r); end
            if (t.y1 - iy1 > 1) begin r = t; r.y0 = iy1; push_free(r); end
        end
        drop_contained();
    endfunction

    function automatic placement_t place_request(bit clear, int unsigned w, int unsigned h);
        placement_t res;
        box_t       p;
        bit         found;
        res   = '0;
        found = 1'b0;
        if (clear) begin
            load_whole_sheet();
        end else if (w <= big_w && h <= big_h) begin
            for (int unsigned i = 0; i < n_free; i++)
                if (w <= free_list[i].x1 - free_list[i].x0 &&
                    h <= free_list[i].y1 - free_list[i].y0) begin
                    p = free_list[i];
                    found = 1'b1;
                end
            if (found) begin
                p.x1 = p.x0 + w;
                p.y1 = p.y0 + h;
                carve_out(p);
                res.granted = 1'b1;
                res.pos_x   = COORD_BITS'(p.x0);
                res.pos_y   = COORD_BITS'(p.y0);
            end
        end
        res.overflow = ovf;
        return res;
    endfunction

    function automatic int unsigned clamp_sheet(logic [COORD_BITS-1:0] v);
        int unsigned u;
        u = v;
        if (u < 1) u = 1;
        if (u > LIM_I) u = LIM_I;
        return u;
    endfunction

    assign placements_left = placements.size();

    always @(posedge aclk) begin
        placement_t got, want;
        if (!aresetn) begin
            sheet_w = SHEET_RESET;
            sheet_h = SHEET_RESET;
            ovf = 1'b0;
            load_whole_sheet();
            placements.delete();
            fails = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_SHEET_WIDTH) sheet_w = clamp_sheet(cfg_data);
                else sheet_h = clamp_sheet(cfg_data);
            end
            if (s_tvalid && s_tready)
                placements.insert(placements.size(),
                                  place_request(s_tuser[0], s_tdata[12:0], s_tdata[25:13]));
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tdata[12:0], m_tdata[25:13], m_tuser[1]};
                if (placements.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual %p", $time, got);
                    fails++;
                end else begin
                    want = placements.pop_front();
                    if (got.granted !== want.granted) begin
                        $display("%0t: granted expected %0d actual %0d",
                                 $time, want.granted, got.granted);
                        fails++;
                    end
                    if (got.pos_x !== want.pos_x) begin
                        $display("%0t: pos_x expected %0d actual %0d",
                                 $time, want.pos_x, got.pos_x);
                        fails++;
                    end
                    if (got.pos_y !== want.pos_y) begin
                        $display("%0t: pos_y expected %0d actual %0d",
                                 $time, want.pos_y, got.pos_y);
                        fails++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $display("%0t: list_overflow expected %0d actual %0d",
                                 $time, want.overflow, got.overflow);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb_maxrects_atlas_allocator.sv =====
// Top of the atlas allocator testbench: clock, reset, stimulus and verdict.
module tb_maxrects_atlas_allocator;
    import mra_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic                  cfg_index;
    logic [COORD_BITS-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;  // req_width, req_height
    logic [0:0]            s_tuser;  // action
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;  // pos_x, pos_y
    logic [1:0]            m_tuser;  // granted, list_overflow

    int fails;
    int placements_left;
    int sent_count;
    int taken_count;

    // Idling mode: 0 none, 1 sender idles, 2 receiver stalls, 3 both do.
    int  idle_mode;
    bit  hold_off;
    int  sheet_side_w, sheet_side_h;

    localparam bit DO_ALLOC = 1'b0;
    localparam bit DO_CLEAR = 1'b1;

    maxrects_atlas_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    mra_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fails(fails), .placements_left(placements_left)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard limit on the run, far beyond the slowest legal run with every
    // request pruning a full free list while the receiver stalls.
    initial begin
        #(12 * 30000000);
        $display("tb_maxrects_atlas_allocator: done, errors");
        $finish;
    end

    // Result counter, used to tell when the block has drained.
    always @(posedge aclk) begin
        if (!aresetn) taken_count <= 0;
        else if (m_tvalid && m_tready) taken_count <= taken_count + 1;
    end

    // The receiver. While hold_off is up it refuses every transfer, so the
    // output register fills, the next request is absorbed, and s_tready drops.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off)
                m_tready <= 1'b0;
            else if (idle_mode == 2)
                m_tready <= ($urandom_range(99) >= 52);
            else if (idle_mode == 3)
                m_tready <= ($urandom_range(99) >= 28);
            else
                m_tready <= 1'b1;
        end
    end

    // Offers one request and returns at the edge where it was taken.
    task automatic send_request(bit act, int unsigned w, int unsigned h);
        int pct;
        pct = (idle_mode == 1) ? 52 : (idle_mode == 3) ? 28 : 0;
        while ($urandom_range(99) < pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'd0, h[12:0], w[12:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (taken_count != sent_count) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Sheet size writes only land while the block is idle, then a clear
    // makes them take effect.
    task automatic set_sheet(int unsigned w, int unsigned h);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SHEET_WIDTH;
        cfg_data  <= w[12:0];
        @(posedge aclk);
        cfg_index <= REG_SHEET_HEIGHT;
        cfg_data  <= h[12:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sheet_side_w = (w == 0) ? 1 : (w > 4096) ? 4096 : w;
        sheet_side_h = (h == 0) ? 1 : (h > 4096) ? 4096 : h;
        send_request(DO_CLEAR, $urandom_range(8191), $urandom_range(8191));
    endtask

    // Mostly sizes that fit several times over, with zero sizes and sizes
    // beyond the sheet mixed in.
    function automatic int unsigned pick_size(int unsigned side);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) return 0;
        if (roll < 16) return $urandom_range(8191);
        if (roll < 26) return $urandom_range(side);
        return $urandom_range((side / 5 > 1) ? side / 5 : 1, 1);
    endfunction

    task automatic random_phase(int mode, int count);
        idle_mode = mode;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 4)
                send_request(DO_CLEAR, $urandom_range(8191), $urandom_range(8191));
            else
                send_request(DO_ALLOC, pick_size(sheet_side_w), pick_size(sheet_side_h));
        end
    endtask

    // Long receiver hold-off, counted here while the sender keeps offering.
    initial begin
        hold_off = 1'b0;
        wait (idle_mode == 0 && sent_count > 20);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (3000) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_SHEET_WIDTH;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = DO_ALLOC;
        sent_count   = 0;
        idle_mode    = 0;
        sheet_side_w = 1024;
        sheet_side_h = 1024;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part on the reset sheet of 1024 by 1024.
        send_request(DO_ALLOC, 0, 0);          // zero size at the last corner
        send_request(DO_ALLOC, 1024, 1024);    // fills the sheet, list empties
        send_request(DO_ALLOC, 1, 1);          // rejected on empty list
        send_request(DO_ALLOC, 0, 0);          // no holder on empty list
        send_request(DO_CLEAR, 8191, 8191);
        send_request(DO_ALLOC, 8191, 1);
        send_request(DO_ALLOC, 1, 8191);
        send_request(DO_ALLOC, 4096, 4096);
        send_request(DO_ALLOC, 1023, 1);       // thin margins are dropped
        send_request(DO_ALLOC, 1, 1023);
        send_request(DO_ALLOC, 2, 2);
        send_request(DO_ALLOC, 1022, 3);
        send_request(DO_ALLOC, 300, 700);
        send_request(DO_ALLOC, 5, 5);
        send_request(DO_CLEAR, 0, 0);
        set_sheet(8191, 8191);                 // saturates to the limit
        send_request(DO_ALLOC, 4096, 4096);
        set_sheet(0, 4096);                    // one pixel wide sheet
        send_request(DO_ALLOC, 1, 4096);
        send_request(DO_ALLOC, 2, 1);

        // Random part: several sheet sizes, one idling mode each.
        set_sheet(4096, 4096);
        random_phase(0, 36);
        set_sheet(640, 480);
        random_phase(1, 34);
        set_sheet(4096, 1);
        random_phase(2, 16);
        set_sheet(37, 900);
        random_phase(2, 18);
        set_sheet(1000, 1000);
        random_phase(3, 34);

        wait_drained();
        repeat (40) @(posedge aclk);
        if (fails == 0 && placements_left == 0)
            $display("tb_maxrects_atlas_allocator: done, clean");
        else
            $display("tb_maxrects_atlas_allocator: done, errors");
        $finish;
    end
endmodule
